FILE: hdl/srto_pkg.sv
// ----------------------------------------------------------------------------
// Section translator package
// Types and constants shared by the section translator chain and its cells.
// ----------------------------------------------------------------------------
package srto_pkg;

   localparam int ADDR_W  = 32;
   localparam int SPAN_W  = ADDR_W + 1;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;
   localparam int IDX_W   = 7;
   localparam int CSR_W   = 2;

   localparam logic [ADDR_W-1:0] DISK_OFFSET_MASK = ~32'h0000_01FF;
   localparam logic [ADDR_W-1:0] ALIGN_ENABLE_MIN = 32'h0000_1000;
   localparam logic [ADDR_W-1:0] FILE_ALIGN_RESET = 32'h0000_0200;
   localparam logic [ADDR_W-1:0] SECT_ALIGN_RESET = 32'h0000_1000;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_RAW_MODULE        = 2'd0,
      CSR_FILE_ALIGNMENT    = 2'd1,
      CSR_SECTION_ALIGNMENT = 2'd2,
      CSR_SECTION_COUNT     = 2'd3
   } csr_index_type;

   // Configuration as seen by every cell; masks are prepared at write time.
   typedef struct packed {
      logic               align_en;
      logic [ADDR_W-1:0]  file_align;
      logic [ADDR_W-1:0]  file_mask;
      logic [ADDR_W-1:0]  sect_align;
      logic [ADDR_W-1:0]  sect_mask;
      logic [COUNT_W-1:0] count;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] mem_offset;
      logic [ADDR_W-1:0] disk_offset;
      logic [ADDR_W-1:0] mem_size;
      logic [ADDR_W-1:0] disk_size;
   } entry_type;

   // One request travelling along the chain, with its running search result.
   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [SLOT_W-1:0] slot;
      entry_type         entry;
      logic [ADDR_W-1:0] address;
      logic              found;
      logic [ADDR_W-1:0] base_offset;
      logic [ADDR_W-1:0] delta;
   } pkt_type;

   // Round a non-zero size up to the alignment; zero stays zero.
   function automatic logic [SPAN_W-1:0] align_up(input logic [ADDR_W-1:0] value,
                                                  input logic [ADDR_W-1:0] mask,
                                                  input logic [ADDR_W-1:0] align);
      logic [ADDR_W-1:0] lower;
      lower = (value - 32'd1) & mask;
      if (value == '0) begin
         return '0;
      end
      return {1'b0, lower} + {1'b0, align};
   endfunction

endpackage

FILE: hdl/srto_cell.sv
// ----------------------------------------------------------------------------
// Section translator cell
// Holds one section entry and tests each passing query against its span.
// ----------------------------------------------------------------------------
module srto_cell #(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  srto_pkg::cfg_type cfg,
   input  srto_pkg::pkt_type up_pkt,
   output srto_pkg::pkt_type down_pkt
);

   localparam logic [srto_pkg::IDX_W-1:0] CELL_IDX = srto_pkg::IDX_W'(INDEX);

   srto_pkg::entry_type                  entry_ff, entry_in;
   logic [srto_pkg::ADDR_W-1:0]          base_ff, base_in;
   logic [srto_pkg::ADDR_W-1:0]          doff_ff, doff_in;
   logic [srto_pkg::SPAN_W-1:0]          span_ff, span_in;
   srto_pkg::pkt_type                    pkt_ff, pkt_in;

   logic                                 load_here;
   logic                                 active;
   logic                                 hit;
   logic [srto_pkg::SPAN_W-1:0]          dsk;
   logic [srto_pkg::SPAN_W-1:0]          msz;
   logic [srto_pkg::SPAN_W-1:0]          diff;

   assign load_here = advance && up_pkt.valid && (up_pkt.kind == srto_pkg::KIND_LOAD)
                      && (srto_pkg::IDX_W'(up_pkt.slot) == CELL_IDX);
   assign active    = srto_pkg::IDX_W'(cfg.count) > CELL_IDX;

   // The derived span is rebuilt every cycle, so it follows both new entries
   // and configuration changes.
   always_comb begin
      entry_in = load_here ? up_pkt.entry : entry_ff;
      if (cfg.align_en) begin
         base_in = entry_in.mem_offset & cfg.sect_mask;
         doff_in = entry_in.disk_offset & srto_pkg::DISK_OFFSET_MASK;
         dsk     = srto_pkg::align_up(entry_in.disk_size, cfg.file_mask, cfg.file_align);
         msz     = srto_pkg::align_up(entry_in.mem_size, cfg.sect_mask, cfg.sect_align);
      end else begin
         base_in = entry_in.mem_offset;
         doff_in = entry_in.disk_offset;
         dsk     = {1'b0, entry_in.disk_size};
         msz     = {1'b0, entry_in.mem_size};
      end
      span_in = (dsk > msz) ? msz : dsk;
   end

   always_comb begin
      diff   = {1'b0, up_pkt.address} - {1'b0, base_ff};
      hit    = up_pkt.valid && (up_pkt.kind == srto_pkg::KIND_QUERY) && !up_pkt.found
               && active && !diff[srto_pkg::ADDR_W]
               && ({1'b0, diff[srto_pkg::ADDR_W-1:0]} < span_ff);
      pkt_in = up_pkt;
      if (hit) begin
         pkt_in.found       = 1'b1;
         pkt_in.base_offset = doff_ff;
         pkt_in.delta       = diff[srto_pkg::ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      base_ff  <= base_in;
      doff_ff  <= doff_in;
      span_ff  <= span_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_ff <= '0;
      end else if (advance) begin
         pkt_ff <= pkt_in;
      end
   end

   assign down_pkt = pkt_ff;

endmodule

FILE: hdl/section_rva_to_file_offset.sv
// ----------------------------------------------------------------------------
// Section table address translator
// Translates relative addresses to file offsets through a chain of section
// cells, one section entry per cell.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   req       in          req_valid / req_ready  kind, slot, section entry, address
//   rsp       out         rsp_valid / rsp_ready  file_offset, found
//   csr       in          csr_we                 csr_index, csr_wdata
//
// Flow: one request is taken per cycle while not stalled. A request is
// registered, then walks the chain of MAX_SECTIONS cells, one cell per cycle
// while not stalled, and its response lands in the output register. The chain
// length sets the latency; one request per cycle passes when not stalled.
// Reset: control state and the configuration return to their defaults. The
// section entries are not cleared; an entry must be loaded before it is
// searched.
// Stalls: the whole chain holds while a response waits in the output
// register and rsp_ready is low; req_ready is low for exactly that time.
//
module section_rva_to_file_offset #(
   parameter int MAX_SECTIONS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_mem_offset,
   input  logic [31:0] req_disk_offset,
   input  logic [31:0] req_mem_size,
   input  logic [31:0] req_disk_size,
   input  logic [31:0] req_query_address,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_file_offset,
   output logic        rsp_found,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Configuration registers. The alignment masks are worked out when the
   // register is written so that the cells see them as plain flops.
   logic                                 raw_ff, raw_in;
   srto_pkg::cfg_type                    cfg_ff, cfg_in;

   // Input stage, output stage and the chain between them.
   srto_pkg::pkt_type                    head_ff, head_in;
   srto_pkg::pkt_type                    chain [MAX_SECTIONS+1];
   srto_pkg::pkt_type                    tail;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [srto_pkg::ADDR_W-1:0]          rsp_offset_ff, rsp_offset_in;
   logic                                 rsp_found_ff, rsp_found_in;
   logic                                 advance;
   logic                                 accept;

   // The chain moves whenever the output register is empty or being drained.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // Configuration write decode.
   always_comb begin
      raw_in = raw_ff;
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (srto_pkg::csr_index_type'(csr_index))
            srto_pkg::CSR_RAW_MODULE: begin
               raw_in = csr_wdata[0];
            end
            srto_pkg::CSR_FILE_ALIGNMENT: begin
               cfg_in.file_align = csr_wdata;
               cfg_in.file_mask  = ~(csr_wdata - 32'd1);
            end
            srto_pkg::CSR_SECTION_ALIGNMENT: begin
               cfg_in.sect_align = csr_wdata;
               cfg_in.sect_mask  = ~(csr_wdata - 32'd1);
               cfg_in.align_en   = csr_wdata >= srto_pkg::ALIGN_ENABLE_MIN;
            end
            srto_pkg::CSR_SECTION_COUNT: begin
               cfg_in.count = csr_wdata[srto_pkg::COUNT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff            <= 1'b0;
         cfg_ff.align_en   <= 1'b1;
         cfg_ff.file_align <= srto_pkg::FILE_ALIGN_RESET;
         cfg_ff.file_mask  <= ~(srto_pkg::FILE_ALIGN_RESET - 32'd1);
         cfg_ff.sect_align <= srto_pkg::SECT_ALIGN_RESET;
         cfg_ff.sect_mask  <= ~(srto_pkg::SECT_ALIGN_RESET - 32'd1);
         cfg_ff.count      <= '0;
      end else begin
         raw_ff <= raw_in;
         cfg_ff <= cfg_in;
      end
   end

   // Build the travelling request. With raw mode off the answer is known at
   // once: the address passes through and the request is already marked as
   // found, so no cell touches it. Otherwise it starts as a miss at offset 0.
   always_comb begin
      head_in.valid             = accept;
      head_in.kind              = srto_pkg::kind_type'(req_kind);
      head_in.slot              = req_slot;
      head_in.entry.mem_offset  = req_mem_offset;
      head_in.entry.disk_offset = req_disk_offset;
      head_in.entry.mem_size    = req_mem_size;
      head_in.entry.disk_size   = req_disk_size;
      head_in.address           = req_query_address;
      head_in.found             = !raw_ff;
      head_in.base_offset       = '0;
      head_in.delta             = raw_ff ? '0 : req_query_address;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else if (advance) begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   // One cell per table entry. Loads and queries travel in order, so a query
   // always sees every load accepted before it and none accepted after it.
   // The first hitting cell marks the request as found and later cells leave
   // it alone, which keeps the lowest-numbered match.
   for (genvar g = 0; g < MAX_SECTIONS; g++) begin : g_cell
      srto_cell #(
         .INDEX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cfg      (cfg_ff),
         .up_pkt   (chain[g]),
         .down_pkt (chain[g+1])
      );
   end

   assign tail = chain[MAX_SECTIONS];

   // Output register. Loads leave the chain without a response. The final
   // add of disk offset and distance into the section is done here, kept out
   // of the cells' compare path.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_offset_in = rsp_offset_ff;
      rsp_found_in  = rsp_found_ff;
      if (advance && tail.valid && (tail.kind == srto_pkg::KIND_QUERY)) begin
         rsp_valid_in  = 1'b1;
         rsp_offset_in = tail.base_offset + tail.delta;
         rsp_found_in  = tail.found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_offset_ff <= rsp_offset_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_file_offset = rsp_offset_ff;
   assign rsp_found       = rsp_found_ff;

   // A miss always reports offset zero.
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_file_offset == '0)
      else $error("miss response carries a non-zero offset");

   // The chain only holds back requests while a response is waiting.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request side stalled without a pending response");

   // A load never reaches the output register as a response.
   a_load_silent : assert property (@(posedge clock) disable iff (reset)
      advance && tail.valid && (tail.kind == srto_pkg::KIND_LOAD)
      |=> !rsp_valid || $past(rsp_valid && !rsp_ready) || $past(rsp_valid_in))
      else $error("load produced a response");

endmodule
